// ===== hw/rtl/particle_circle_collision_resolve_core_defines.svh =====
// assertion macros for the collision resolve rtl
`ifndef PARTICLE_CIRCLE_COLLISION_RESOLVE_CORE_DEFINES_SVH
`define PARTICLE_CIRCLE_COLLISION_RESOLVE_CORE_DEFINES_SVH

// checked only out of reset
`define PCCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PCCR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pccr_pkg.sv =====
// types, stage map and helpers for the collision resolve pipeline
`default_nettype none
package pccr_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        particle_radius;
        logic signed [31:0] obstacle_x;
        logic signed [31:0] obstacle_y;
        logic [30:0]        obstacle_radius;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               overlapped;
        logic               bounced;
    } out_t;

    // per-beat data that rides along the pipeline
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] obs_x;
        logic signed [31:0] obs_y;
        logic [31:0]        min_dst;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [30:0]        nxm;
        logic [30:0]        nym;
        logic               sx;
        logic               sy;
        logic               zero;
        logic               in_box;
        logic               ovl;
        logic               bnc;
    } side_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [31:0] rem;
        logic        nb;
        logic [30:0] q;
    } div_lane_t;

    typedef struct packed {
        logic [31:0] divisor;
        div_lane_t   lx;
        div_lane_t   ly;
    } div_st_t;

    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 31;

    localparam int ST_IN    = 0;
    localparam int ST_SUB   = 1;
    localparam int ST_SQ    = 2;
    localparam int ST_D2    = 3;
    localparam int ST_ROOT  = ST_D2 + SQRT_CELLS;
    localparam int ST_QUO   = ST_ROOT + DIV_CELLS;
    localparam int ST_NORM  = ST_QUO + 1;
    localparam int ST_PROD  = ST_NORM + 1;
    localparam int ST_RND   = ST_PROD + 1;
    localparam int ST_PUSH  = ST_RND + 1;
    localparam int ST_DOT   = ST_PUSH + 1;
    localparam int ST_TPROD = ST_DOT + 1;
    localparam int ST_TRND  = ST_TPROD + 1;
    localparam int ST_REFL  = ST_TRND + 1;
    localparam int ST_RABS  = ST_REFL + 1;
    localparam int ST_DPROD = ST_RABS + 1;
    localparam int ST_OUT   = ST_DPROD + 1;

    localparam logic [30:0] NORM_ONE   = 31'h4000_0000;
    localparam logic [16:0] DAMP_RESET = 17'h1_0000;
    localparam logic        REG_DAMPING = 1'b0;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sd2147483647)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (x < -40'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pccr_sqrt_cell.sv =====
// one digit step of the integer square root chain
`default_nettype none
module pccr_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  pccr_pkg::sqrt_st_t  d,
    output pccr_pkg::sqrt_st_t  q
);
    import pccr_pkg::*;

    sqrt_st_t   q_reg;
    sqrt_st_t   q_next;
    logic [34:0] rem2;
    logic [34:0] trial;

    always_comb
    begin
        rem2  = {d.rem[32:0], d.rad[63:62]};
        trial = {1'b0, d.root, 2'b01};
        q_next.rad = {d.rad[61:0], 2'b00};
        if (rem2 >= trial)
        begin
            q_next.rem  = rem2 - trial;
            q_next.root = {d.root[30:0], 1'b1};
        end
        else
        begin
            q_next.rem  = rem2;
            q_next.root = {d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/pccr_div_cell.sv =====
// one quotient bit of the two-lane normal divider chain
`default_nettype none
module pccr_div_cell (
    input  logic               clk,
    input  logic               en,
    input  pccr_pkg::div_st_t  d,
    output pccr_pkg::div_st_t  q
);
    import pccr_pkg::*;

    div_st_t q_reg;
    div_st_t q_next;

    function automatic div_lane_t step(input div_lane_t l, input logic [31:0] divisor);
        div_lane_t   r;
        logic [32:0] r2;
        r2   = {l.rem, l.nb};
        r.nb = 1'b0;
        if (r2 >= {1'b0, divisor})
        begin
            r2  = r2 - {1'b0, divisor};
            r.q = {l.q[29:0], 1'b1};
        end
        else
        begin
            r.q = {l.q[29:0], 1'b0};
        end
        r.rem = r2[31:0];
        return r;
    endfunction

    always_comb
    begin
        q_next.divisor = d.divisor;
        q_next.lx      = step(d.lx, d.divisor);
        q_next.ly      = step(d.ly, d.divisor);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/particle_circle_collision_resolve_core.sv =====
// Particle against circular obstacle collision resolve, Q16.16 fixed point. The block takes
// one particle beat per clock and gives one result beat per clock while the result is not
// stalled. The pipeline length is set by the cell chains: 32 square-root cells (one root
// bit each) and 31 divider cells (one normal bit each, both axes side by side), plus the
// multiply, round and saturate stages around them. A stalled result holds the whole
// pipeline; the input register still takes one more beat while it is empty. Damping is
// written over the APB port at address 0 (decoded from paddr[2] only) and is used as given, above 1.0 too.
`default_nettype none
`include "particle_circle_collision_resolve_core_defines.svh"
module particle_circle_collision_resolve_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           particle_valid,
    output logic           particle_ready,
    input  pccr_pkg::in_t  particle,
    output logic           result_valid,
    input  logic           result_ready,
    output pccr_pkg::out_t result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import pccr_pkg::*;

    logic [16:0] damping_reg;

    logic [ST_OUT:0] vld_reg;
    logic [ST_OUT:0] vld_next;
    logic            en;
    logic            load0;

    in_t   in_reg;
    side_t side_reg [1:ST_DPROD];
    side_t side_in  [1:ST_DPROD];
    out_t  out_reg;
    out_t  out_next;

    logic [63:0]        sqx_reg, sqy_reg, msq_reg;
    logic [63:0]        d2_reg;
    logic [64:0]        d2_sum;
    logic               ovl_c;
    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    logic [31:0]        mind;

    sqrt_st_t sq_st [0:SQRT_CELLS];
    div_st_t  dv_st [0:DIV_CELLS];

    logic [30:0]        qx, qy, nxm_c, nym_c;
    logic signed [31:0] nxs_reg, nys_reg;
    logic [62:0]        pmx_reg, pmy_reg;
    logic signed [63:0] pvx_reg, pvy_reg;
    logic [33:0]        posrx_reg, posry_reg;
    logic signed [63:0] raw_reg;
    logic [63:0]        absd_reg;
    logic signed [39:0] offx, offy;
    logic signed [31:0] npx, npy;
    logic [33:0]        dotm_reg;
    logic [64:0]        tx_reg, ty_reg;
    logic [35:0]        trx_reg, try_reg;
    logic signed [36:0] rx_reg, ry_reg;
    logic [36:0]        arx_reg, ary_reg;
    logic               srx_reg, sry_reg, srx2_reg, sry2_reg;
    logic [53:0]        prx_reg, pry_reg;
    logic [37:0]        rndx, rndy;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DAMPING) ? {15'b0, damping_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= DAMP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_DAMPING))
        begin
            damping_reg <= pwdata[16:0];
        end
    end

    // pipeline control
    assign en             = !vld_reg[ST_OUT] || result_ready;
    assign load0          = en || !vld_reg[ST_IN];
    assign particle_ready = load0;
    assign result_valid   = vld_reg[ST_OUT];
    assign result         = out_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load0)
        begin
            vld_next[ST_IN] = particle_valid;
        end
        if (en)
        begin
            vld_next[ST_OUT:1] = vld_reg[ST_OUT-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load0 && particle_valid)
        begin
            in_reg <= particle;
        end
    end

    // offset, radii sum, overlap test, normal clamp, push-out position, and the per-stage side data
    always_comb
    begin
        dx   = $signed({in_reg.pos_x[31], in_reg.pos_x})
             - $signed({in_reg.obstacle_x[31], in_reg.obstacle_x});
        dy   = $signed({in_reg.pos_y[31], in_reg.pos_y})
             - $signed({in_reg.obstacle_y[31], in_reg.obstacle_y});
        adx  = dx[32] ? 33'(-dx) : 33'(dx);
        ady  = dy[32] ? 33'(-dy) : 33'(dy);
        mind = {1'b0, in_reg.particle_radius} + {1'b0, in_reg.obstacle_radius};

        d2_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        ovl_c  = side_reg[ST_SQ].in_box && !d2_sum[64] && (d2_sum[63:0] < msq_reg);

        qx    = dv_st[DIV_CELLS].lx.q;
        qy    = dv_st[DIV_CELLS].ly.q;
        nxm_c = side_reg[ST_QUO].zero ? NORM_ONE : ((qx > NORM_ONE) ? NORM_ONE : qx);
        nym_c = side_reg[ST_QUO].zero ? 31'b0 : ((qy > NORM_ONE) ? NORM_ONE : qy);

        offx = side_reg[ST_RND].sx ? -$signed({6'b0, posrx_reg}) : $signed({6'b0, posrx_reg});
        offy = side_reg[ST_RND].sy ? -$signed({6'b0, posry_reg}) : $signed({6'b0, posry_reg});
        npx  = sat32($signed({{8{side_reg[ST_RND].obs_x[31]}}, side_reg[ST_RND].obs_x}) + offx);
        npy  = sat32($signed({{8{side_reg[ST_RND].obs_y[31]}}, side_reg[ST_RND].obs_y}) + offy);

        for (int k = 2; k <= ST_DPROD; k++)
        begin
            side_in[k] = side_reg[k-1];
        end

        side_in[ST_SUB].pos_x   = in_reg.pos_x;
        side_in[ST_SUB].pos_y   = in_reg.pos_y;
        side_in[ST_SUB].vel_x   = in_reg.vel_x;
        side_in[ST_SUB].vel_y   = in_reg.vel_y;
        side_in[ST_SUB].obs_x   = in_reg.obstacle_x;
        side_in[ST_SUB].obs_y   = in_reg.obstacle_y;
        side_in[ST_SUB].min_dst = mind;
        side_in[ST_SUB].ax      = adx[31:0];
        side_in[ST_SUB].ay      = ady[31:0];
        side_in[ST_SUB].nxm     = '0;
        side_in[ST_SUB].nym     = '0;
        side_in[ST_SUB].sx      = dx[32];
        side_in[ST_SUB].sy      = dy[32];
        side_in[ST_SUB].zero    = (dx == 33'sd0) && (dy == 33'sd0);
        side_in[ST_SUB].in_box  = (adx < {1'b0, mind}) && (ady < {1'b0, mind});
        side_in[ST_SUB].ovl     = 1'b0;
        side_in[ST_SUB].bnc     = 1'b0;

        side_in[ST_D2].ovl   = ovl_c;
        side_in[ST_NORM].nxm = nxm_c;
        side_in[ST_NORM].nym = nym_c;

        // push out, and mark a bounce when moving inward
        if (side_reg[ST_RND].ovl)
        begin
            side_in[ST_PUSH].pos_x = npx;
            side_in[ST_PUSH].pos_y = npy;
        end
        side_in[ST_PUSH].bnc = side_reg[ST_RND].ovl && raw_reg[63];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= ST_DPROD; k++)
            begin
                side_reg[k] <= side_in[k];
            end
        end
    end

    // squares and the distance-squared sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= 64'(side_reg[ST_SUB].ax) * 64'(side_reg[ST_SUB].ax);
            sqy_reg <= 64'(side_reg[ST_SUB].ay) * 64'(side_reg[ST_SUB].ay);
            msq_reg <= 64'(side_reg[ST_SUB].min_dst) * 64'(side_reg[ST_SUB].min_dst);
            d2_reg  <= d2_sum[63:0];
        end
    end

    // square root chain
    assign sq_st[0].rad  = d2_reg;
    assign sq_st[0].rem  = '0;
    assign sq_st[0].root = '0;

    for (genvar j = 0; j < SQRT_CELLS; j++)
    begin : g_sqrt
        pccr_sqrt_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (sq_st[j]),
            .q   (sq_st[j+1])
        );
    end

    // divider chain, quotient is |d| * 2^30 / dist
    assign dv_st[0].divisor = sq_st[SQRT_CELLS].root;
    assign dv_st[0].lx.rem  = {1'b0, side_reg[ST_ROOT].ax[31:1]};
    assign dv_st[0].lx.nb   = side_reg[ST_ROOT].ax[0];
    assign dv_st[0].lx.q    = '0;
    assign dv_st[0].ly.rem  = {1'b0, side_reg[ST_ROOT].ay[31:1]};
    assign dv_st[0].ly.nb   = side_reg[ST_ROOT].ay[0];
    assign dv_st[0].ly.q    = '0;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        pccr_div_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (dv_st[j]),
            .q   (dv_st[j+1])
        );
    end

    // response arithmetic
    always_comb
    begin
        rndx = 38'((65'(prx_reg) + 65'h8000) >> 16);
        rndy = 38'((65'(pry_reg) + 65'h8000) >> 16);

        out_next.new_pos_x  = side_reg[ST_DPROD].pos_x;
        out_next.new_pos_y  = side_reg[ST_DPROD].pos_y;
        out_next.overlapped = side_reg[ST_DPROD].ovl;
        out_next.bounced    = side_reg[ST_DPROD].bnc;
        if (side_reg[ST_DPROD].bnc)
        begin
            out_next.new_vel_x = sat32(srx2_reg ? -$signed({2'b0, rndx}) : $signed({2'b0, rndx}));
            out_next.new_vel_y = sat32(sry2_reg ? -$signed({2'b0, rndy}) : $signed({2'b0, rndy}));
        end
        else
        begin
            out_next.new_vel_x = side_reg[ST_DPROD].vel_x;
            out_next.new_vel_y = side_reg[ST_DPROD].vel_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxs_reg <= side_reg[ST_QUO].sx ? -$signed({1'b0, nxm_c}) : $signed({1'b0, nxm_c});
            nys_reg <= side_reg[ST_QUO].sy ? -$signed({1'b0, nym_c}) : $signed({1'b0, nym_c});

            pmx_reg <= 63'(side_reg[ST_NORM].nxm) * 63'(side_reg[ST_NORM].min_dst);
            pmy_reg <= 63'(side_reg[ST_NORM].nym) * 63'(side_reg[ST_NORM].min_dst);
            pvx_reg <= 64'(side_reg[ST_NORM].vel_x) * 64'(nxs_reg);
            pvy_reg <= 64'(side_reg[ST_NORM].vel_y) * 64'(nys_reg);

            posrx_reg <= 34'((pmx_reg + 63'h2000_0000) >> 30);
            posry_reg <= 34'((pmy_reg + 63'h2000_0000) >> 30);
            raw_reg   <= pvx_reg + pvy_reg;

            absd_reg <= raw_reg[63] ? 64'(-raw_reg) : 64'(raw_reg);

            dotm_reg <= 34'((absd_reg + 64'h2000_0000) >> 30);

            tx_reg <= 65'(dotm_reg) * 65'(side_reg[ST_DOT].nxm);
            ty_reg <= 65'(dotm_reg) * 65'(side_reg[ST_DOT].nym);

            trx_reg <= 36'((tx_reg + 65'h1000_0000) >> 29);
            try_reg <= 36'((ty_reg + 65'h1000_0000) >> 29);

            // dot is negative here, so the correction runs along the normal sign
            rx_reg <= side_reg[ST_TRND].sx
                    ? 37'(side_reg[ST_TRND].vel_x) - $signed({1'b0, trx_reg})
                    : 37'(side_reg[ST_TRND].vel_x) + $signed({1'b0, trx_reg});
            ry_reg <= side_reg[ST_TRND].sy
                    ? 37'(side_reg[ST_TRND].vel_y) - $signed({1'b0, try_reg})
                    : 37'(side_reg[ST_TRND].vel_y) + $signed({1'b0, try_reg});

            arx_reg <= rx_reg[36] ? 37'(-rx_reg) : 37'(rx_reg);
            ary_reg <= ry_reg[36] ? 37'(-ry_reg) : 37'(ry_reg);
            srx_reg <= rx_reg[36];
            sry_reg <= ry_reg[36];

            prx_reg  <= 54'(arx_reg) * 54'(damping_reg);
            pry_reg  <= 54'(ary_reg) * 54'(damping_reg);
            srx2_reg <= srx_reg;
            sry2_reg <= sry_reg;

            out_reg <= out_next;
        end
    end

    `PCCR_ASSERT(a_stall_freezes_pipe, !en |=> $stable(vld_reg[ST_OUT:1]), "pipe moved while stalled")
    `PCCR_ASSERT_ALWAYS(a_ready_low_only_when_full, !particle_ready |-> (vld_reg[ST_IN] && !en), "input blocked with room")
    `PCCR_ASSERT(a_accept_lands, (particle_valid && particle_ready) |=> vld_reg[ST_IN], "accepted beat lost")
    `PCCR_ASSERT(a_bounce_needs_overlap, (result_valid && result.bounced) |-> result.overlapped, "bounce without overlap")

endmodule
`default_nettype wire
